// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the tracker core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SLT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/slt_pkg.sv -----
package slt_pkg;

  localparam logic [1:0] OP_SET_RANGE = 2'd0;
  localparam logic [1:0] OP_GET       = 2'd1;
  localparam logic [1:0] OP_SET_UNI   = 2'd2;

  localparam logic [1:0] CFG_MIPS    = 2'd0;
  localparam logic [1:0] CFG_LAYERS  = 2'd1;
  localparam logic [1:0] CFG_ASPECTS = 2'd2;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_UNIFORM = 2'd1,
    ST_IGNORED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_IGNORE  = 2'd0,
    K_UNIFORM = 2'd1,
    K_RANGE   = 2'd2,
    K_GET     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_EXPAND = 3'd1,
    B_WALK   = 3'd2,
    B_READ   = 3'd3,
    B_RESP   = 3'd4
  } bstate_t;

  // Range for a set command; m0/l0 carry the coordinates of a get.
  typedef struct packed {
    kind_t       kind;
    logic [5:0]  slots;
    logic [4:0]  m0;
    logic [4:0]  mend;
    logic [6:0]  l0;
    logic [6:0]  lend;
    logic        hit;
    logic [2:0]  get_slot;
    logic [7:0]  code;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_layout;
    status_t    status;
  } res_t;

endpackage

// ----- hdl/slt_fifo.sv -----
module slt_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  T     wdata,
  input  logic rd,
  output T     rdata,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                entries [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

// ----- hdl/slt_front.sv -----
module slt_front #(
  parameter int LAYOUT_BITS = 8
) (
  input  logic              [1:0] opcode,
  input  logic              [5:0] aspect_sel,
  input  logic              [7:0] first_mip,
  input  logic              [7:0] mip_span,
  input  logic                    mips_to_end,
  input  logic              [7:0] first_layer,
  input  logic              [7:0] layer_span,
  input  logic                    layers_to_end,
  input  logic              [7:0] new_layout,
  input  logic              [5:0] asp_eff,
  input  logic              [4:0] mips_eff,
  input  logic              [6:0] layers_eff,
  output slt_pkg::cmd_t           cmd
);

  localparam logic [7:0] CODE_MASK =
    (LAYOUT_BITS >= 8) ? 8'hFF : 8'((1 << LAYOUT_BITS) - 1);

  logic [5:0] am;
  logic [4:0] m0, mrest, mn;
  logic [6:0] l0, lrest, ln;
  logic [2:0] low_slot;
  logic       empty_rng, full_rng;

  always_comb begin
    am = aspect_sel & asp_eff;
    // clamp base to the count, span to what remains
    m0    = (first_mip < {3'b0, mips_eff}) ? first_mip[4:0] : mips_eff;
    mrest = mips_eff - m0;
    mn    = mips_to_end ? mrest
          : ((mip_span < {3'b0, mrest}) ? mip_span[4:0] : mrest);
    l0    = (first_layer < {1'b0, layers_eff}) ? first_layer[6:0] : layers_eff;
    lrest = layers_eff - l0;
    ln    = layers_to_end ? lrest
          : ((layer_span < {1'b0, lrest}) ? layer_span[6:0] : lrest);
    empty_rng = (am == '0) || (mn == '0) || (ln == '0);
    full_rng  = (am == asp_eff) && (m0 == '0) && (mn == mips_eff)
             && (l0 == '0) && (ln == layers_eff);
    low_slot = '0;
    for (int i = 5; i >= 0; i--) begin
      if (am[i]) low_slot = 3'(i);
    end

    cmd.slots    = am;
    cmd.m0       = m0;
    cmd.mend     = m0 + mn;
    cmd.l0       = l0;
    cmd.lend     = l0 + ln;
    cmd.hit      = 1'b0;
    cmd.get_slot = low_slot;
    cmd.code     = new_layout & CODE_MASK;
    unique case (opcode)
      slt_pkg::OP_SET_RANGE: begin
        if (empty_rng)     cmd.kind = slt_pkg::K_IGNORE;
        else if (full_rng) cmd.kind = slt_pkg::K_UNIFORM;
        else               cmd.kind = slt_pkg::K_RANGE;
      end
      slt_pkg::OP_GET: begin
        cmd.kind = slt_pkg::K_GET;
        cmd.m0   = first_mip[4:0];
        cmd.l0   = first_layer[6:0];
        cmd.hit  = (am != '0) && (first_mip < {3'b0, mips_eff})
                && (first_layer < {1'b0, layers_eff});
      end
      slt_pkg::OP_SET_UNI: cmd.kind = slt_pkg::K_UNIFORM;
      default:             cmd.kind = slt_pkg::K_IGNORE;
    endcase
  end

endmodule

// ----- hdl/slt_back.sv -----
module slt_back #(
  parameter int ASPECT_SLOTS = 6,
  parameter int MAX_MIPS     = 16,
  parameter int MAX_LAYERS   = 64,
  parameter int LAYOUT_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_clear,
  input  logic          [5:0] asp_eff,
  input  logic          [4:0] mips_eff,
  input  logic          [6:0] layers_eff,
  input  slt_pkg::cmd_t       cmd,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output slt_pkg::res_t       res,
  output logic                uniform
);

  localparam int SW = (ASPECT_SLOTS > 1) ? $clog2(ASPECT_SLOTS) : 1;
  localparam int MW = (MAX_MIPS > 1) ? $clog2(MAX_MIPS) : 1;
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = (LAYOUT_BITS < 8) ? LAYOUT_BITS : 8;
  localparam int AW = SW + MW + LW;

  slt_pkg::bstate_t state, state_next;
  slt_pkg::cmd_t    pend;
  slt_pkg::res_t    res_q;
  logic             uni;
  logic [7:0]       ucode;
  logic [5:0]       wmask;
  logic [4:0]       wmip, wm0, wmend;
  logic [6:0]       wlay, wl0, wlend;
  logic [7:0]       wcode;
  logic [5:0]       lowbit;
  logic [2:0]       wslot;
  logic             last_l, last_m, walk_last, walking, take;
  logic [AW-1:0]    waddr, raddr;
  logic [CW-1:0]    mem [2**AW];
  logic [CW-1:0]    rdata;

  assign res     = res_q;
  assign uniform = uni;

  always_comb begin
    lowbit = wmask & (~wmask + 6'd1);
    wslot  = '0;
    for (int i = 5; i >= 0; i--) begin
      if (wmask[i]) wslot = 3'(i);
    end
  end

  assign last_l    = (wlay + 7'd1) == wlend;
  assign last_m    = (wmip + 5'd1) == wmend;
  assign walk_last = last_l && last_m && ((wmask & ~lowbit) == '0);
  assign walking   = (state == slt_pkg::B_EXPAND) || (state == slt_pkg::B_WALK);
  assign take      = cmd_pop;
  assign waddr     = {SW'(wslot), MW'(wmip), LW'(wlay)};
  assign raddr     = {SW'(cmd.get_slot), MW'(cmd.m0), LW'(cmd.l0)};

  always_ff @(posedge clk) begin
    if (rst) state <= slt_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      slt_pkg::B_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            slt_pkg::K_RANGE: state_next = uni ? slt_pkg::B_EXPAND : slt_pkg::B_WALK;
            slt_pkg::K_GET:   state_next = (cmd.hit && !uni) ? slt_pkg::B_READ
                                                             : slt_pkg::B_RESP;
            default:          state_next = slt_pkg::B_RESP;
          endcase
        end
      end
      slt_pkg::B_EXPAND: if (walk_last) state_next = slt_pkg::B_WALK;
      slt_pkg::B_WALK:   if (walk_last) state_next = slt_pkg::B_RESP;
      slt_pkg::B_READ:   state_next = slt_pkg::B_RESP;
      slt_pkg::B_RESP: begin
        res_push   = 1'b1;
        state_next = slt_pkg::B_IDLE;
      end
      default: state_next = slt_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uni   <= 1'b1;
      ucode <= '0;
    end else if (cfg_clear) begin
      uni   <= 1'b1;
      ucode <= '0;
    end else if (take) begin
      if (cmd.kind == slt_pkg::K_UNIFORM) begin
        uni   <= 1'b1;
        ucode <= cmd.code;
      end else if (cmd.kind == slt_pkg::K_RANGE) begin
        uni <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= cmd;
      res_q.read_layout <= (cmd.kind == slt_pkg::K_GET && cmd.hit && uni) ? ucode : '0;
      unique case (cmd.kind)
        slt_pkg::K_RANGE:   res_q.status <= slt_pkg::ST_WRITTEN;
        slt_pkg::K_UNIFORM: res_q.status <= slt_pkg::ST_UNIFORM;
        slt_pkg::K_GET:     res_q.status <= slt_pkg::ST_READ;
        default:            res_q.status <= slt_pkg::ST_IGNORED;
      endcase
      // expand over the live image first, with the old uniform code
      if (uni) begin
        wmask <= asp_eff;
        wm0   <= '0;
        wmend <= mips_eff;
        wl0   <= '0;
        wlend <= layers_eff;
        wmip  <= '0;
        wlay  <= '0;
        wcode <= ucode;
      end else begin
        wmask <= cmd.slots;
        wm0   <= cmd.m0;
        wmend <= cmd.mend;
        wl0   <= cmd.l0;
        wlend <= cmd.lend;
        wmip  <= cmd.m0;
        wlay  <= cmd.l0;
        wcode <= cmd.code;
      end
    end else if (state == slt_pkg::B_EXPAND && walk_last) begin
      wmask <= pend.slots;
      wm0   <= pend.m0;
      wmend <= pend.mend;
      wl0   <= pend.l0;
      wlend <= pend.lend;
      wmip  <= pend.m0;
      wlay  <= pend.l0;
      wcode <= pend.code;
    end else if (walking) begin
      if (!last_l) begin
        wlay <= wlay + 7'd1;
      end else begin
        wlay <= wl0;
        if (!last_m) begin
          wmip <= wmip + 5'd1;
        end else begin
          wmip  <= wm0;
          wmask <= wmask & ~lowbit;
        end
      end
    end else if (state == slt_pkg::B_READ) begin
      res_q.read_layout <= 8'(rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (walking) mem[waddr] <= wcode[CW-1:0];
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/subresource_layout_tracker_core.sv -----
// Layout tracker for the subresources of one image.
// Commands enter on a queue-style port (push/full): an item is taken when
// push is high and full is low. Results leave the same way (empty/pop): the
// oldest result is on read_layout/status while empty is low, taken with pop.
// Image size and aspects are set over the APB port at addresses 0, 4, 8;
// any write to them puts the tracker back to one uniform, undefined layout.
// A command queue of two entries sits between the classifier and the
// executing sequencer, and a two-entry result queue follows it.
// A command is taken only once the last result is pushed; get, set-uniform
// and ignored commands then go on to the result. A range write walks
// its range one store entry per cycle through the single write port; the
// first range write after uniform mode first expands the whole image the
// same way. Reset clears both queues and returns to uniform undefined with
// the registers at 1 mip, 1 layer, color only. A stalled result side fills
// the result queue and then holds the sequencer, then the command queue.
`include "assert_macros.svh"

module subresource_layout_tracker_core #(
  parameter int ASPECT_SLOTS = 6,
  parameter int MAX_MIPS     = 16,
  parameter int MAX_LAYERS   = 64,
  parameter int LAYOUT_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [5:0]  aspect_sel,
  input  logic [7:0]  first_mip,
  input  logic [7:0]  mip_span,
  input  logic        mips_to_end,
  input  logic [7:0]  first_layer,
  input  logic [7:0]  layer_span,
  input  logic        layers_to_end,
  input  logic [7:0]  new_layout,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_layout,
  output logic [1:0]  status
);

  localparam logic [5:0] SLOT_MASK =
    (ASPECT_SLOTS >= 6) ? 6'h3F : 6'((1 << ASPECT_SLOTS) - 1);

  logic [4:0]    mip_count;
  logic [6:0]    layer_count_cfg;
  logic [5:0]    image_aspects;
  logic [4:0]    mips_eff;
  logic [6:0]    layers_eff;
  logic [5:0]    asp_eff, asp_m;
  logic          cfg_wr, cfg_clear;
  slt_pkg::cmd_t front_cmd, q_cmd;
  slt_pkg::res_t back_res, out_res;
  logic          cmd_empty, cmd_pop, res_full, res_push, uniform;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mip_count       <= 5'd1;
      layer_count_cfg <= 7'd1;
      image_aspects   <= 6'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        slt_pkg::CFG_MIPS:    mip_count       <= pwdata[4:0];
        slt_pkg::CFG_LAYERS:  layer_count_cfg <= pwdata[6:0];
        slt_pkg::CFG_ASPECTS: image_aspects   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_wr && (paddr[3:2] != 2'd3);

  always_comb begin
    unique case (paddr[3:2])
      slt_pkg::CFG_MIPS:    prdata = {27'b0, mip_count};
      slt_pkg::CFG_LAYERS:  prdata = {25'b0, layer_count_cfg};
      slt_pkg::CFG_ASPECTS: prdata = {26'b0, image_aspects};
      default:              prdata = '0;
    endcase
  end

  // zero counts read as one, large ones saturate
  always_comb begin
    if (mip_count == '0)                   mips_eff = 5'd1;
    else if (6'(mip_count) > 6'(MAX_MIPS)) mips_eff = 5'(MAX_MIPS);
    else                                   mips_eff = mip_count;
    if (layer_count_cfg == '0)                        layers_eff = 7'd1;
    else if (12'(layer_count_cfg) > 12'(MAX_LAYERS))  layers_eff = 7'(MAX_LAYERS);
    else                                              layers_eff = layer_count_cfg;
    asp_m   = image_aspects & SLOT_MASK;
    asp_eff = (asp_m == '0) ? 6'd1 : asp_m;
  end

  slt_front #(.LAYOUT_BITS(LAYOUT_BITS)) u_front (
    .opcode, .aspect_sel, .first_mip, .mip_span, .mips_to_end,
    .first_layer, .layer_span, .layers_to_end, .new_layout,
    .asp_eff, .mips_eff, .layers_eff,
    .cmd(front_cmd)
  );

  slt_fifo #(.T(slt_pkg::cmd_t), .DEPTH(2)) u_cmdq (
    .clk, .rst, .wr(push), .wdata(front_cmd), .rd(cmd_pop),
    .rdata(q_cmd), .full(full), .empty(cmd_empty)
  );

  slt_back #(
    .ASPECT_SLOTS(ASPECT_SLOTS), .MAX_MIPS(MAX_MIPS),
    .MAX_LAYERS(MAX_LAYERS), .LAYOUT_BITS(LAYOUT_BITS)
  ) u_back (
    .clk, .rst, .cfg_clear, .asp_eff, .mips_eff, .layers_eff,
    .cmd(q_cmd), .cmd_empty, .cmd_pop, .res_full, .res_push,
    .res(back_res), .uniform
  );

  slt_fifo #(.T(slt_pkg::res_t), .DEPTH(2)) u_resq (
    .clk, .rst, .wr(res_push), .wdata(back_res), .rd(pop),
    .rdata(out_res), .full(res_full), .empty(empty)
  );

  assign read_layout = out_res.read_layout;
  assign status      = out_res.status;

  `SLT_ASSERT_NOW(a_res_room, clk, rst, res_push, !res_full, "result pushed into full queue")
  `SLT_ASSERT_NOW(a_cmd_avail, clk, rst, cmd_pop, !cmd_empty, "command taken from empty queue")
  `SLT_ASSERT_NEXT(a_cfg_uni, clk, rst, cfg_clear, uniform, "config write left tracker expanded")

endmodule
